>>> src/rtt_pkg.sv
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int DEFAULT_ENTRIES = 16;

  localparam int OP_W    = 2;
  localparam int ENT_W   = 4;
  localparam int IVL_W   = 16;
  localparam int LIM_W   = 8;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [IVL_W-1:0]  interval;
    logic [LIM_W-1:0]  attempts;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/rtt_ram.sv
`timescale 1ns / 1ps

module rtt_ram
  import rtt_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = DEFAULT_ENTRIES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/retransmit_timer_table.sv
`timescale 1ns / 1ps
// Add, remove and update: the single result is registered in the execute state, and
// busy is high for one cycle, so a new item is accepted only after busy has fallen.
// Tick: one table entry is read per cycle from the entry memory, and busy stays high
// until the done result appears; event results stream out and the done result ends the item.
// The receiver cannot stall. Reset clears the valid bits and the control state only;
// the entry memory is not cleared, since the contents of invalid entries are never used.

module retransmit_timer_table
  import rtt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [ENT_W-1:0]  entry,
  input  logic [IVL_W-1:0]  resend_interval,
  input  logic [LIM_W-1:0]  attempt_limit,
  input  logic [TIME_W-1:0] now_ms,
  output logic              strobe,
  output logic [KIND_W-1:0] kind,
  output logic [ENT_W-1:0]  entry_index,
  output logic              last
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_LAST = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;

  logic [OP_W-1:0]    op_r;
  logic [ENT_W-1:0]   entry_r;
  logic [IVL_W-1:0]   ivl_r;
  logic [LIM_W-1:0]   lim_r;
  logic [TIME_W-1:0]  now_r;
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   rd_cnt;
  logic [IDX_W-1:0]   pidx;
  logic               pend;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  entry_t             rd_word;

  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               in_range;
  logic [IDX_W-1:0]   ent_idx;
  logic               due;
  logic [LIM_W-1:0]   add_attempts;

  rtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_cnt),
    .rdata(rd_word)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign in_range     = ({28'd0, entry_r} < 32'(ENTRIES));
  assign ent_idx      = IDX_W'(entry_r);
  assign due          = pend && valid[pidx] && (now_r >= rd_word.deadline);
  assign add_attempts = (lim_r == '0) ? '0 : lim_r - LIM_W'(1);
  assign busy         = (state != ST_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = '{deadline: now_r + TIME_W'(rd_word.interval),
                  interval: rd_word.interval,
                  attempts: rd_word.attempts - LIM_W'(1)};
    if (state == ST_EXEC) begin
      if (op_r == OP_ADD) begin
        ram_we    = free_found;
        ram_waddr = free_idx;
        ram_wdata = '{deadline: now_r + TIME_W'(ivl_r), interval: ivl_r,
                      attempts: add_attempts};
      end else if (op_r == OP_UPDATE) begin
        ram_we    = in_range;
        ram_waddr = ent_idx;
        ram_wdata = '{deadline: now_r, interval: ivl_r, attempts: lim_r};
      end
    end else if (due && (rd_word.attempts != '0)) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      pend   <= 1'b0;
      valid  <= '0;
      rd_cnt <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_r    <= op;
            entry_r <= entry;
            ivl_r   <= resend_interval;
            lim_r   <= attempt_limit;
            now_r   <= now_ms;
            rd_cnt  <= '0;
            state   <= (op == OP_TICK) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_EXEC: begin
          strobe      <= 1'b1;
          last        <= 1'b1;
          kind        <= KIND_DONE;
          entry_index <= entry_r;
          unique case (op_r)
            OP_ADD: begin
              if (free_found) begin
                valid[free_idx] <= 1'b1;
                kind            <= KIND_ADDED;
                entry_index     <= ENT_W'(free_idx);
              end else begin
                kind        <= KIND_FULL;
                entry_index <= '0;
              end
            end
            OP_REMOVE: begin
              if (in_range) begin
                valid[ent_idx] <= 1'b0;
              end
            end
            OP_UPDATE: begin
              if (in_range) begin
                valid[ent_idx] <= 1'b1;
              end
            end
            default: begin
            end
          endcase
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          pend   <= 1'b1;
          pidx   <= rd_cnt;
          rd_cnt <= rd_cnt + IDX_W'(1);
          if (rd_cnt == LAST_IDX) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          pend  <= 1'b0;
          state <= ST_FIN;
        end
        ST_FIN: begin
          strobe      <= 1'b1;
          kind        <= KIND_DONE;
          entry_index <= '0;
          last        <= 1'b1;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (due) begin
        strobe      <= 1'b1;
        last        <= 1'b0;
        entry_index <= ENT_W'(pidx);
        if (rd_word.attempts == '0) begin
          valid[pidx] <= 1'b0;
          kind        <= KIND_TIMEOUT;
        end else begin
          kind <= KIND_RESEND;
        end
      end
    end
  end

endmodule

>>> src/rtt_checker.sv
`timescale 1ns / 1ps

module rtt_checker
  import rtt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [KIND_W-1:0] kind,
  input logic [ENT_W-1:0]  entry_index,
  input logic              last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted item did not raise busy.");

  a_event_kind: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> (kind == KIND_RESEND) || (kind == KIND_TIMEOUT))
    else $error("Non-final result carries a wrong kind.");

  a_event_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("Non-final result while idle.");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == KIND_FULL) |-> entry_index == '0)
    else $error("Table full result has a nonzero index.");

  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("Result directly follows a final result.");

endmodule

bind retransmit_timer_table rtt_checker u_rtt_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .kind       (kind),
  .entry_index(entry_index),
  .last       (last)
);
